// File: rtl/trimmed_mean_sample_averager_unit_assert.svh
// Assertion macros shared by the trimmed-mean averager modules.
`ifndef TRIMMED_MEAN_SAMPLE_AVERAGER_UNIT_ASSERT_SVH
`define TRIMMED_MEAN_SAMPLE_AVERAGER_UNIT_ASSERT_SVH

// Condition that must hold in the same cycle as its trigger.
`define TMSA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define TMSA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tmsa_pkg.sv
// Package of types and constants for the trimmed-mean sample averager.
package tmsa_pkg;

   // Default sample width and fixed register widths.
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int COUNT_BITS          = 8;
   localparam int CSR_DATA_BITS       = 8;
   localparam int CSR_INDEX_BITS      = 1;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_SAMPLE_COUNT   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WARMUP_DISCARD = 1'd1;

   // Batch-size reset value, smallest usable batch size and number of items trimmed.
   localparam logic [COUNT_BITS-1:0] SAMPLE_COUNT_RESET = 8'd10;
   localparam logic [COUNT_BITS-1:0] MIN_COUNT          = 8'd3;
   localparam logic [COUNT_BITS-1:0] TRIM_DROP          = 8'd2;

   // Controller states.
   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_TRIM,
      ST_DIVIDE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic trim;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ends_batch;
      logic rsp_pending;
      logic div_done;
   } ctrl_status_type;

endpackage

// File: rtl/tmsa_div.sv
// Restoring divider that produces one quotient bit per cycle, with saturation.
module tmsa_div #(
   parameter int DIVIDEND_BITS = tmsa_pkg::SAMPLE_BITS_DEFAULT + tmsa_pkg::COUNT_BITS,
   parameter int DIVISOR_BITS  = tmsa_pkg::COUNT_BITS,
   parameter int QUOT_BITS     = tmsa_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [QUOT_BITS-1:0]     quotient
);

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_BITS-1:0] quot_ff, quot_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  div_ff, div_in;
   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS:0]    diff;
   logic                     fits;

   // One restoring step: shift in the next dividend bit and try to subtract.
   assign trial = {rem_ff, quot_ff[DIVIDEND_BITS-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DIVIDEND_BITS);
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so the low bits hold it.
         rem_in  = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         quot_in = {quot_ff[DIVIDEND_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   // Clamp a quotient that does not fit the sample width.
   assign done     = done_ff;
   assign quotient = (|quot_ff[DIVIDEND_BITS-1:QUOT_BITS]) ? {QUOT_BITS{1'b1}}
                                                           : quot_ff[QUOT_BITS-1:0];

endmodule

// File: rtl/tmsa_datapath.sv
// Datapath: registers, batch accumulation, trimming, divider and result register.
`include "trimmed_mean_sample_averager_unit_assert.svh"

module tmsa_datapath #(
   parameter int SAMPLE_BITS = tmsa_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tmsa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tmsa_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   input  tmsa_pkg::ctrl_cmd_type              cmd,
   output tmsa_pkg::ctrl_status_type           status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [SAMPLE_BITS-1:0]              rsp_average
);

   localparam int CB       = tmsa_pkg::COUNT_BITS;
   localparam int SUM_BITS = SAMPLE_BITS + CB;

   logic [CB-1:0]          count_ff;
   logic                   warmup_ff;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [CB-1:0]          taken_ff, taken_in;
   logic                   pending_ff, pending_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] average_ff;
   logic [CB-1:0]          count_eff;
   logic [CB:0]            next_taken;
   logic                   discard_now;
   logic [SUM_BITS-1:0]    trimmed;
   logic                   div_done;
   logic [SAMPLE_BITS-1:0] div_quot;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= tmsa_pkg::SAMPLE_COUNT_RESET;
         warmup_ff <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tmsa_pkg::REG_SAMPLE_COUNT:   count_ff  <= csr_wdata[CB-1:0];
            tmsa_pkg::REG_WARMUP_DISCARD: warmup_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Batch bookkeeping: small counts act as the minimum.
   assign count_eff   = (count_ff < tmsa_pkg::MIN_COUNT) ? tmsa_pkg::MIN_COUNT : count_ff;
   assign next_taken  = {1'b0, taken_ff} + 1'b1;
   assign discard_now = (taken_ff == '0) && warmup_ff && pending_ff;

   assign status.ends_batch  = !discard_now && (next_taken >= {1'b0, count_eff});
   assign status.rsp_pending = rsp_valid_ff;
   assign status.div_done    = div_done;

   // Accumulate an item, or drop the warm-up item, or clear at batch end.
   always_comb begin
      sum_in     = sum_ff;
      max_in     = max_ff;
      min_in     = min_ff;
      taken_in   = taken_ff;
      pending_in = pending_ff;
      if (cmd.trim) begin
         sum_in     = '0;
         max_in     = '0;
         min_in     = '0;
         taken_in   = '0;
         pending_in = 1'b1;
      end else if (cmd.take) begin
         if (discard_now) begin
            pending_in = 1'b0;
         end else begin
            if (taken_ff == '0) begin
               sum_in = SUM_BITS'(req_sample);
               max_in = req_sample;
               min_in = req_sample;
            end else begin
               sum_in = sum_ff + SUM_BITS'(req_sample);
               if (req_sample > max_ff) begin
                  max_in = req_sample;
               end
               if (req_sample < min_ff) begin
                  min_in = req_sample;
               end
            end
            taken_in = next_taken[CB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         max_ff     <= '0;
         min_ff     <= '0;
         taken_ff   <= '0;
         pending_ff <= 1'b1;
      end else begin
         sum_ff     <= sum_in;
         max_ff     <= max_in;
         min_ff     <= min_in;
         taken_ff   <= taken_in;
         pending_ff <= pending_in;
      end
   end

   // Drop the largest and smallest item from the finished batch.
   assign trimmed = sum_ff - SUM_BITS'(max_ff) - SUM_BITS'(min_ff);

   tmsa_div #(
      .DIVIDEND_BITS (SUM_BITS),
      .DIVISOR_BITS  (CB),
      .QUOT_BITS     (SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.trim),
      .dividend (trimmed),
      .divisor  (count_eff - tmsa_pkg::TRIM_DROP),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Result register, held until the receiver takes the item.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (div_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (div_done) begin
         average_ff <= div_quot;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = average_ff;

   // A finished quotient must never land on an untaken result.
   `TMSA_ASSERT_SAME(a_no_overwrite, clock, reset, div_done, !rsp_valid_ff,
                     "result register overwritten before it was taken")
   // Clearing at batch end rearms the warm-up discard.
   `TMSA_ASSERT_NEXT(a_trim_clears, clock, reset, cmd.trim,
                     (taken_ff == '0) && pending_ff,
                     "batch state not cleared after trimming")

endmodule

// File: rtl/tmsa_ctrl.sv
// Controller: sequences accumulation, trimming and the division at batch end.
`include "trimmed_mean_sample_averager_unit_assert.svh"

module tmsa_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tmsa_pkg::ctrl_status_type  status,
   output tmsa_pkg::ctrl_cmd_type     cmd
);

   tmsa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmsa_pkg::ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         tmsa_pkg::ST_ACCUM: begin
            // A batch-ending item waits until the last result has been taken.
            req_ready = !(status.ends_batch && status.rsp_pending);
            cmd.take  = req_valid && req_ready;
            if (cmd.take && status.ends_batch) begin
               state_in = tmsa_pkg::ST_TRIM;
            end
         end
         tmsa_pkg::ST_TRIM: begin
            cmd.trim = 1'b1;
            state_in = tmsa_pkg::ST_DIVIDE;
         end
         tmsa_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = tmsa_pkg::ST_ACCUM;
            end
         end
         default: state_in = tmsa_pkg::ST_ACCUM;
      endcase
   end

   // The divider only finishes while the controller waits for it.
   `TMSA_ASSERT_SAME(a_done_in_divide, clock, reset, status.div_done,
                     state_ff == tmsa_pkg::ST_DIVIDE,
                     "divider finished outside the divide state")
   // Trimming always hands over to the divide state.
   `TMSA_ASSERT_NEXT(a_trim_to_divide, clock, reset, cmd.trim,
                     state_ff == tmsa_pkg::ST_DIVIDE && !req_ready,
                     "trim not followed by division")

endmodule

// File: rtl/trimmed_mean_sample_averager_unit.sv
// Top level of the trimmed-mean sample averager.
//
// Samples arrive on the req_ channel (valid/ready) and trimmed means leave on
// the rsp_ channel (valid/ready). Each accepted item is folded into the batch
// by the accumulator registers directly, so items can be taken on consecutive
// cycles. With warm-up discard enabled, the first item of each batch is
// dropped. On the last item of a batch the block enters a trim state that
// drops the largest and smallest item and starts a one-bit-per-cycle
// divider; its done flag is registered, and the result register then captures
// the quotient. No item is accepted while the block trims and divides. The
// result sits in an output register: items of the next batch are accepted
// while it waits, and only the item that would end the next batch is held off
// until the receiver has taken it.
// The csr_ port writes the batch size (index 0) and the warm-up discard
// enable (index 1); write only while the block is idle. A synchronous reset
// restores a batch size of ten with warm-up discard on and empties the batch.
module trimmed_mean_sample_averager_unit #(
   parameter int SAMPLE_BITS = tmsa_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tmsa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tmsa_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [SAMPLE_BITS-1:0]              rsp_average
);

   tmsa_pkg::ctrl_cmd_type    cmd;
   tmsa_pkg::ctrl_status_type status;

   tmsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tmsa_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_sample  (req_sample),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_average (rsp_average)
   );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the trimmed-mean sample averager.
`timescale 1ns / 1ps

module tb;

   localparam int SAMPLE_BITS    = tmsa_pkg::SAMPLE_BITS_DEFAULT;
   localparam int SUM_BITS       = SAMPLE_BITS + 8;
   localparam int RESET_CYCLES   = 12;
   // Trim, divide and output register, with some margin.
   localparam int DRAIN_CYCLES   = SAMPLE_BITS + 24;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 426;
   localparam longint unsigned SAMPLE_MAX = (64'd1 << SAMPLE_BITS) - 1;

   // Receiver stall patterns.
   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_SPARSE,
      STALL_LIGHT
   } stall_mode_type;

   // Predicts the trimmed mean of each batch and checks the averages that come out.
   class trim_mean_scoreboard;
      logic [tmsa_pkg::COUNT_BITS-1:0] batch_size;
      logic                            warmup_en;
      logic [SUM_BITS-1:0]             batch_sum;
      logic [SAMPLE_BITS-1:0]          batch_max;
      logic [SAMPLE_BITS-1:0]          batch_min;
      logic [tmsa_pkg::COUNT_BITS-1:0] batch_taken;
      logic                            warmup_due;
      logic [SAMPLE_BITS-1:0]          expected_averages [$];
      int                              mismatches;
      int                              averages_checked;
      int                              saturated;

      function new();
         batch_size       = tmsa_pkg::SAMPLE_COUNT_RESET;
         warmup_en        = 1'b1;
         batch_sum        = '0;
         batch_max        = '0;
         batch_min        = '0;
         batch_taken      = '0;
         warmup_due       = 1'b1;
         mismatches       = 0;
         averages_checked = 0;
         saturated        = 0;
      endfunction

      function void write_reg(input logic [tmsa_pkg::CSR_INDEX_BITS-1:0] idx,
                              input logic [tmsa_pkg::CSR_DATA_BITS-1:0] data);
         if (idx == tmsa_pkg::REG_SAMPLE_COUNT) begin
            batch_size = data[tmsa_pkg::COUNT_BITS-1:0];
         end else if (idx == tmsa_pkg::REG_WARMUP_DISCARD) begin
            warmup_en = data[0];
         end
      endfunction

      function int pending();
         return expected_averages.size();
      endfunction

      // Folds one accepted sample into the batch; queues the average on the last one.
      function void note_sample(input logic [SAMPLE_BITS-1:0] s);
         logic [tmsa_pkg::COUNT_BITS-1:0] eff_count;
         longint unsigned                 trimmed;
         longint unsigned                 avg;
         eff_count = (batch_size < tmsa_pkg::MIN_COUNT) ? tmsa_pkg::MIN_COUNT : batch_size;
         // The dummy conversion at the head of a batch is dropped.
         if (batch_taken == 0 && warmup_en && warmup_due) begin
            warmup_due = 1'b0;
            return;
         end
         if (batch_taken == 0) begin
            batch_sum = SUM_BITS'(s);
            batch_max = s;
            batch_min = s;
         end else begin
            batch_sum = batch_sum + SUM_BITS'(s);
            if (s > batch_max) batch_max = s;
            if (s < batch_min) batch_min = s;
         end
         batch_taken = batch_taken + 1'b1;
         if (batch_taken != 0 && batch_taken < eff_count) return;
         trimmed = 64'(batch_sum) - 64'(batch_max) - 64'(batch_min);
         avg = trimmed / 64'(eff_count - tmsa_pkg::TRIM_DROP);
         // A count lowered mid-batch can leave too many samples in the sum.
         if (avg > SAMPLE_MAX) begin
            avg = SAMPLE_MAX;
            saturated++;
         end
         expected_averages.push_back(avg[SAMPLE_BITS-1:0]);
         batch_sum   = '0;
         batch_max   = '0;
         batch_min   = '0;
         batch_taken = '0;
         warmup_due  = 1'b1;
      endfunction

      // Compares one accepted average with the oldest prediction.
      function void check_average(input logic [SAMPLE_BITS-1:0] actual);
         logic [SAMPLE_BITS-1:0] predicted;
         if (expected_averages.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: average %0d arrived with none expected", actual);
            return;
         end
         predicted = expected_averages.pop_front();
         averages_checked++;
         if (actual !== predicted) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: average %0d: expected %0d, got %0d",
                        averages_checked, predicted, actual);
         end
      endfunction
   endclass

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                csr_wr_en   = 1'b0;
   logic [tmsa_pkg::CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [tmsa_pkg::CSR_DATA_BITS-1:0]  csr_wdata   = '0;
   logic                                req_valid   = 1'b0;
   logic                                req_ready;
   logic [SAMPLE_BITS-1:0]              req_sample  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready   = 1'b0;
   logic [SAMPLE_BITS-1:0]              rsp_average;

   trim_mean_scoreboard sb = new();

   int             samples_accepted = 0;
   int             idle_cycles      = 0;
   int             burst_left       = 0;
   int             settings_written = 0;
   int             size_lo          = 255;
   int             size_hi          = 0;
   bit             hold_request     = 1'b0;
   int             hold_left        = 0;
   int             mode_left        = 0;
   int             sparse_phase     = 0;
   stall_mode_type stall_mode       = STALL_NONE;

   trimmed_mean_sample_averager_unit #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_average(rsp_average)
   );

   always #10 clock = ~clock;

   // Monitor both channels at the rising edge and keep the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_sample(req_sample);
            samples_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_average(rsp_average);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("trimmed_mean_sample_averager_unit test failed");
            $finish;
         end
      end
   end

   // Receiver: changing stall patterns, plus one long hold when asked for.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = LONG_HOLD;
      end
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(20, 80);
      end else begin
         mode_left--;
      end
      sparse_phase = (sparse_phase + 1) % 4;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            STALL_NONE:   rsp_ready <= 1'b1;
            STALL_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
            STALL_SPARSE: rsp_ready <= (sparse_phase == 0);
            default:      rsp_ready <= ($urandom_range(0, 9) < 8);
         endcase
      end
   end

   // Offers one sample from a falling edge and returns at a falling edge once it is
   // taken; valid stays high within a burst and drops for a gap between bursts.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 10);
      end
   endtask

   // Stops offering, waits for every predicted average, then lets the block settle.
   task automatic drain_results();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Writes one register from a falling edge, then drops the enable and waits
   // before returning; the block must be idle.
   task automatic write_csr(input logic [tmsa_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [tmsa_pkg::CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(idx, data);
      settings_written++;
      if (idx == tmsa_pkg::REG_SAMPLE_COUNT) begin
         if (int'(data) < size_lo) size_lo = int'(data);
         if (int'(data) > size_hi) size_hi = int'(data);
      end
      @(negedge clock);
   endtask

   // Random sample with extra weight on the extremes.
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return SAMPLE_BITS'($urandom_range(0, 15));
         3:       return SAMPLE_BITS'(SAMPLE_MAX - $urandom_range(0, 15));
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   initial begin
      logic [SAMPLE_BITS-1:0] opening [11];
      int                     random_sent;
      int                     phase;
      int                     phase_items;
      logic [7:0]             new_size;
      logic [7:0]             warm_data;

      opening = '{16'h1234, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001,
                  16'hFFFE, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00};
      random_sent = 0;
      phase       = 0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: dummy sample dropped, then a batch of ten extremes.
      foreach (opening[i]) send_sample(opening[i]);
      drain_results();

      // A batch size of zero acts as three; upper warm-up bits are ignored.
      write_csr(tmsa_pkg::REG_SAMPLE_COUNT, 8'd0);
      write_csr(tmsa_pkg::REG_WARMUP_DISCARD, 8'hFE);
      repeat (3) send_sample('1);
      drain_results();

      // Lower the size mid-batch so the trimmed mean saturates.
      write_csr(tmsa_pkg::REG_SAMPLE_COUNT, 8'd10);
      repeat (9) send_sample('1);
      drain_results();
      write_csr(tmsa_pkg::REG_SAMPLE_COUNT, 8'd2);
      send_sample('1);
      drain_results();

      // Random phases, each under its own setting; batches run across phases.
      while (random_sent < RANDOM_ITEMS) begin
         if (phase == 0) begin
            new_size    = 8'd3;
            warm_data   = 8'h00;
            phase_items = 60;
         end else if (phase == 2) begin
            new_size    = 8'd255;
            warm_data   = 8'($urandom_range(0, 255));
            phase_items = 256;
         end else begin
            case ($urandom_range(0, 7))
               0:       new_size = 8'd0;
               1:       new_size = 8'd1;
               2:       new_size = 8'd2;
               3:       new_size = 8'd3;
               4:       new_size = 8'd4;
               default: new_size = 8'($urandom_range(3, 16));
            endcase
            warm_data   = 8'($urandom_range(0, 255));
            phase_items = $urandom_range(15, 45);
         end
         write_csr(tmsa_pkg::REG_SAMPLE_COUNT, new_size);
         write_csr(tmsa_pkg::REG_WARMUP_DISCARD, warm_data);
         // The receiver backs off for a long stretch while samples keep coming.
         if (phase == 0) hold_request = 1'b1;
         repeat (phase_items) begin
            send_sample(pick_sample());
            random_sent++;
         end
         drain_results();
         phase++;
      end

      drain_results();
      $display("Summary: %0d samples accepted, %0d averages checked (%0d saturated).",
               samples_accepted, sb.averages_checked, sb.saturated);
      $display("Summary: %0d register writes over %0d phases, batch sizes %0d to %0d.",
               settings_written, phase, size_lo, size_hi);
      if (sb.pending() != 0) begin
         $display("ERROR: %0d averages never arrived", sb.pending());
      end
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("trimmed_mean_sample_averager_unit test passed");
      end else begin
         $display("trimmed_mean_sample_averager_unit test failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/tmsa_pkg.sv
rtl/tmsa_div.sv
rtl/tmsa_datapath.sv
rtl/tmsa_ctrl.sv
rtl/trimmed_mean_sample_averager_unit.sv
tb/tb.sv
